### hw/rtl/asdu_pkg.sv
// ----------------------------------------------------------------------------
// asdu_pkg
// Shared types and constants for the attribute shadow dirty-update block.
// ----------------------------------------------------------------------------
package asdu_pkg;

    localparam int unsigned ADDR_W     = 14;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned ENTRY_W    = 7;
    localparam int unsigned OFFS_W     = 6;
    localparam int unsigned DEPTH      = 128;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [ADDR_W-1:0] ATTR_OFFSET  = 14'h03c0;
    localparam logic [ADDR_W-1:0] TABLE_A_RST  = 14'd8192;
    localparam logic [ADDR_W-1:0] TABLE_B_RST  = 14'd11264;

    // operation codes
    localparam logic [1:0] OP_SET    = 2'd0;
    localparam logic [1:0] OP_ENABLE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;
    localparam logic [1:0] OP_UPLOAD = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_A = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_B = 1'b1;

    typedef struct packed {
        logic [1:0] operation;
        logic [4:0] tile_x;
        logic [3:0] tile_y;
        logic [1:0] palette;
        logic       table_select;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] write_address;
        logic [BYTE_W-1:0] write_data;
        logic              last;
    } t_out_item;

    typedef enum logic [1:0] {
        RD_INPUT,
        RD_DIRTY,
        RD_UPLOAD
    } t_rd_src;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET_WR,
        ST_EMIT_RD,
        ST_EMIT,
        ST_UP_RD,
        ST_UP_OUT
    } t_state;

    typedef struct packed {
        logic    cap_item;
        logic    rd_en;
        t_rd_src rd_src;
        logic    wr_en;
        logic    dirty_load;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    out_load;
        logic    out_upload;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_eq_dirty;
        logic cnt_last;
        logic out_free;
    } t_dp_stat;

endpackage

### hw/rtl/attribute_shadow_dirty_update.sv
// Steps: a set reads and then writes its byte, and when it evicts the old
//   dirty byte reads and sends that byte; enable ends on acceptance; flush
//   sends the dirty byte if any; upload reads and sends all 64 table bytes.
// Throughput: one item at a time; set and flush are bound by the 128-byte
//   shadow taking one read or write at a time, upload by one read per byte.
// Reset: synchronous, active low; per-entry valid bits clear the shadow
//   (no clearing pass), flags cleared, base registers to defaults.
// ----------------------------------------------------------------------------
// attribute_shadow_dirty_update
// Shadow of two attribute tables with single-byte dirty write-back and
// full-table upload to video memory.
// ----------------------------------------------------------------------------
module attribute_shadow_dirty_update (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input items
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  asdu_pkg::t_in_item               i_in,
    // result items (video memory writes)
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output asdu_pkg::t_out_item              o_out,
    // configuration writes
    input  logic                             i_cfg_we,
    input  logic [asdu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [asdu_pkg::ADDR_W-1:0]      i_cfg_data
);

    asdu_pkg::t_dp_cmd  cmd;
    asdu_pkg::t_dp_stat stat;

    // Controller: one item at a time; the output register decouples the
    // result side, so an item is taken while a result still waits.
    asdu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in.operation),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath: shadow memory (registered read), dirty index, upload
    // counter, base address registers and the output register.
    asdu_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

### hw/rtl/asdu_dp.sv
// ----------------------------------------------------------------------------
// asdu_dp
// Datapath: shadow memory, dirty index, upload counter, base registers and
// the output register.
// ----------------------------------------------------------------------------
module asdu_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  asdu_pkg::t_in_item               i_in,
    input  asdu_pkg::t_dp_cmd                i_cmd,
    output asdu_pkg::t_dp_stat               o_stat,
    input  logic                             i_cfg_we,
    input  logic [asdu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [asdu_pkg::ADDR_W-1:0]      i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output asdu_pkg::t_out_item              o_out
);

    logic [asdu_pkg::BYTE_W-1:0]  mem [asdu_pkg::DEPTH];
    logic [asdu_pkg::DEPTH-1:0]   r_vld_bits;

    logic [asdu_pkg::ADDR_W-1:0]  r_base_a;
    logic [asdu_pkg::ADDR_W-1:0]  r_base_b;
    logic [asdu_pkg::ENTRY_W-1:0] r_idx;
    logic [2:0]                   r_sh;
    logic [1:0]                   r_pal;
    logic                         r_sel;
    logic [asdu_pkg::ENTRY_W-1:0] r_dirty;
    logic [asdu_pkg::OFFS_W-1:0]  r_cnt;
    logic [asdu_pkg::BYTE_W-1:0]  r_rd_data;
    logic                         r_rd_vld;
    logic [asdu_pkg::ENTRY_W-1:0] r_rd_addr;
    logic                         r_out_valid;
    asdu_pkg::t_out_item          r_out;

    logic [asdu_pkg::ENTRY_W-1:0] in_idx;
    logic [asdu_pkg::ENTRY_W-1:0] rd_addr;
    logic [asdu_pkg::BYTE_W-1:0]  old_byte;
    logic [asdu_pkg::BYTE_W-1:0]  slot_mask;
    logic [asdu_pkg::BYTE_W-1:0]  new_byte;
    logic [asdu_pkg::ADDR_W-1:0]  out_base;
    logic [asdu_pkg::ADDR_W-1:0]  out_addr;
    logic                         out_free;

    // byte = {table, row, column}
    assign in_idx = {i_in.tile_x[4], i_in.tile_y[3:1], i_in.tile_x[3:1]};

    always_comb begin
        unique case (i_cmd.rd_src)
            asdu_pkg::RD_INPUT: begin
                rd_addr = (i_in.operation == asdu_pkg::OP_SET) ? in_idx : r_dirty;
            end
            asdu_pkg::RD_DIRTY:  rd_addr = r_dirty;
            asdu_pkg::RD_UPLOAD: rd_addr = {r_sel, r_cnt};
            default:             rd_addr = r_dirty;
        endcase
    end

    // unwritten entries read as zero
    assign old_byte  = r_rd_vld ? r_rd_data : '0;
    assign slot_mask = 8'h03 << r_sh;
    assign new_byte  = (old_byte & ~slot_mask) | ({6'b0, r_pal} << r_sh);

    assign out_base = r_rd_addr[asdu_pkg::ENTRY_W-1] ? r_base_b : r_base_a;
    assign out_addr = out_base + asdu_pkg::ATTR_OFFSET
                    + {{(asdu_pkg::ADDR_W-asdu_pkg::OFFS_W){1'b0}},
                       r_rd_addr[asdu_pkg::OFFS_W-1:0]};

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[r_idx] <= new_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_bits  <= '0;
            r_base_a    <= asdu_pkg::TABLE_A_RST;
            r_base_b    <= asdu_pkg::TABLE_B_RST;
            r_dirty     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.wr_en) begin
                r_vld_bits[r_idx] <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    asdu_pkg::CFG_TABLE_A: r_base_a <= i_cfg_data;
                    asdu_pkg::CFG_TABLE_B: r_base_b <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.dirty_load) begin
                r_dirty <= r_idx;
            end
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_item) begin
            r_idx <= in_idx;
            r_sh  <= {i_in.tile_y[0], i_in.tile_x[0], 1'b0};
            r_pal <= i_in.palette;
            r_sel <= i_in.table_select;
        end
        if (i_cmd.rd_en) begin
            r_rd_vld  <= r_vld_bits[rd_addr];
            r_rd_addr <= rd_addr;
        end
        if (i_cmd.out_load) begin
            r_out.write_address <= out_addr;
            r_out.write_data    <= old_byte;
            r_out.last          <= i_cmd.out_upload ? (&r_cnt) : 1'b1;
        end
    end

    assign o_stat.idx_eq_dirty = (r_idx == r_dirty);
    assign o_stat.cnt_last     = &r_cnt;
    assign o_stat.out_free     = out_free;
    assign o_out_valid         = r_out_valid;
    assign o_out               = r_out;

endmodule

### hw/rtl/asdu_ctrl.sv
// ----------------------------------------------------------------------------
// asdu_ctrl
// Controller: sequences each item and holds the buffering and dirty flags.
// ----------------------------------------------------------------------------
module asdu_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_op,
    output logic                o_in_ready,
    input  asdu_pkg::t_dp_stat  i_stat,
    output asdu_pkg::t_dp_cmd   o_cmd
);

    asdu_pkg::t_state r_state;
    asdu_pkg::t_state n_state;
    logic             r_buffering;
    logic             n_buffering;
    logic             r_dirty_vld;
    logic             n_dirty_vld;
    logic             accept;
    logic             set_marks;

    assign accept    = (r_state == asdu_pkg::ST_IDLE) && i_in_valid;
    // set touches a byte other than the dirty one while buffering
    assign set_marks = r_buffering && (!r_dirty_vld || !i_stat.idx_eq_dirty);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            asdu_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_op)
                        asdu_pkg::OP_SET:    n_state = asdu_pkg::ST_SET_WR;
                        asdu_pkg::OP_ENABLE: n_state = asdu_pkg::ST_IDLE;
                        asdu_pkg::OP_FLUSH: begin
                            n_state = r_dirty_vld ? asdu_pkg::ST_EMIT : asdu_pkg::ST_IDLE;
                        end
                        asdu_pkg::OP_UPLOAD: n_state = asdu_pkg::ST_UP_RD;
                        default:             n_state = asdu_pkg::ST_IDLE;
                    endcase
                end
            end
            asdu_pkg::ST_SET_WR: begin
                n_state = (set_marks && r_dirty_vld) ? asdu_pkg::ST_EMIT_RD
                                                     : asdu_pkg::ST_IDLE;
            end
            asdu_pkg::ST_EMIT_RD: n_state = asdu_pkg::ST_EMIT;
            asdu_pkg::ST_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = asdu_pkg::ST_IDLE;
                end
            end
            asdu_pkg::ST_UP_RD: n_state = asdu_pkg::ST_UP_OUT;
            asdu_pkg::ST_UP_OUT: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.cnt_last ? asdu_pkg::ST_IDLE : asdu_pkg::ST_UP_RD;
                end
            end
            default: n_state = asdu_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.rd_src = asdu_pkg::RD_INPUT;
        o_in_ready  = 1'b0;
        unique case (r_state)
            asdu_pkg::ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.cap_item = i_in_valid;
                o_cmd.rd_en    = i_in_valid;
                o_cmd.cnt_clr  = i_in_valid;
            end
            asdu_pkg::ST_SET_WR: begin
                o_cmd.wr_en      = 1'b1;
                o_cmd.dirty_load = r_buffering && !r_dirty_vld;
            end
            asdu_pkg::ST_EMIT_RD: begin
                // old dirty byte is read before the index moves on
                o_cmd.rd_en      = 1'b1;
                o_cmd.rd_src     = asdu_pkg::RD_DIRTY;
                o_cmd.dirty_load = 1'b1;
            end
            asdu_pkg::ST_EMIT: begin
                o_cmd.out_load = i_stat.out_free;
            end
            asdu_pkg::ST_UP_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = asdu_pkg::RD_UPLOAD;
            end
            asdu_pkg::ST_UP_OUT: begin
                o_cmd.out_load   = i_stat.out_free;
                o_cmd.out_upload = 1'b1;
                o_cmd.cnt_inc    = i_stat.out_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_buffering = r_buffering;
        n_dirty_vld = r_dirty_vld;
        if (accept && (i_op == asdu_pkg::OP_ENABLE)) begin
            n_buffering = 1'b1;
            n_dirty_vld = 1'b0;
        end else if (accept && (i_op == asdu_pkg::OP_FLUSH)) begin
            n_buffering = 1'b0;
        end else if ((r_state == asdu_pkg::ST_SET_WR) && set_marks) begin
            n_dirty_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= asdu_pkg::ST_IDLE;
            r_buffering <= 1'b0;
            r_dirty_vld <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_buffering <= n_buffering;
            r_dirty_vld <= n_dirty_vld;
        end
    end

endmodule

### dv/attribute_shadow_dirty_update_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// attribute_shadow_dirty_update_tb
// Self-checking bench for the attribute shadow: a queue-fed driver pushes
// set/enable/flush/upload items, a predictor tracks the shadow bytes and the
// dirty mark, and a monitor checks every video-memory write in order.
// ----------------------------------------------------------------------------
module attribute_shadow_dirty_update_tb;

    import asdu_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int RST_CYCLES  = 7;
    localparam int STALL_LIMIT = 4000;  // cycles with no handshake at all
    localparam int SETTLE_GAP  = 12;    // longer than an enable or a set with no result
    localparam int DRAIN_GAP   = 150;   // longer than a full upload
    localparam int MAX_REPORTS = 10;

    // ------------------------------------------------------------------------
    // DUT signals, all known from time zero
    // ------------------------------------------------------------------------
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in       = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [ADDR_W-1:0]    i_cfg_data = '0;

    attribute_shadow_dirty_update dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_in_item  attr_ops_q[$];      // items waiting for the driver
    t_out_item exp_writes_q[$];    // predicted video-memory writes, oldest first
    int        gap_pct = 17;       // idle percentage on both channels
    int        mismatch_count = 0;
    int        quiet_cycles = 0;

    // Predictor copy of the block's state and registers
    logic [BYTE_W-1:0]  shadow_mem [DEPTH];
    logic [ENTRY_W-1:0] dirty_idx;
    logic               dirty_set;
    logic               buffer_en;
    logic [ADDR_W-1:0]  base_a;
    logic [ADDR_W-1:0]  base_b;

    // last set coordinates, reused to hit the dirty byte again
    logic [4:0] near_x = '0;
    logic [3:0] near_y = '0;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    // One emitted byte: the upper half of the shadow maps to the second table.
    // The address sum wraps at 14 bits by truncation.
    function automatic t_out_item pred_write(input logic [ENTRY_W-1:0] entry,
                                             input logic is_last);
        t_out_item         w;
        logic [ADDR_W-1:0] base;
        base              = entry[ENTRY_W-1] ? base_b : base_a;
        w.write_address   = base + ATTR_OFFSET + ADDR_W'(entry[OFFS_W-1:0]);
        w.write_data      = shadow_mem[entry];
        w.last            = is_last;
        return w;
    endfunction

    task automatic shadow_apply(input t_in_item it);
        logic [ENTRY_W-1:0] idx;
        logic [2:0]         sh;
        logic [BYTE_W-1:0]  mask;
        case (it.operation)
            OP_SET: begin
                // byte = {table bit, row, column}; slot from the low bits
                idx  = {it.tile_x[4], it.tile_y[3:1], it.tile_x[3:1]};
                sh   = {it.tile_y[0], it.tile_x[0], 1'b0};
                mask = 8'h03 << sh;
                shadow_mem[idx] = (shadow_mem[idx] & ~mask)
                                | (BYTE_W'(it.palette) << sh);
                if (buffer_en && (!dirty_set || idx != dirty_idx)) begin
                    if (dirty_set)
                        exp_writes_q.push_back(pred_write(dirty_idx, 1'b1));
                    dirty_idx = idx;
                    dirty_set = 1'b1;
                end
            end
            OP_ENABLE: begin
                buffer_en = 1'b1;
                dirty_set = 1'b0;
            end
            OP_FLUSH: begin
                // dirty mark survives a flush
                if (dirty_set)
                    exp_writes_q.push_back(pred_write(dirty_idx, 1'b1));
                buffer_en = 1'b0;
            end
            default: begin  // OP_UPLOAD
                for (int i = 0; i < 64; i++)
                    exp_writes_q.push_back(
                        pred_write({it.table_select, OFFS_W'(i)}, i == 63));
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Driver: feeds attr_ops_q, predicts on each accepted item
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : item_driver
        logic fire;
        fire = i_in_valid && o_in_ready;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (fire)
                shadow_apply(i_in);
            // valid holds until accepted; only then may a gap be inserted
            if (!i_in_valid || fire) begin
                if (attr_ops_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    i_in       <= attr_ops_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each accepted write against the oldest prediction
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch %s: expected %0h, got %0h", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin : write_monitor
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_writes_q.size() == 0) begin
                note_mismatch("unexpected write, address", 0, o_out.write_address);
            end else begin
                want = exp_writes_q.pop_front();
                if (o_out.write_address !== want.write_address)
                    note_mismatch("write_address", want.write_address, o_out.write_address);
                if (o_out.write_data !== want.write_data)
                    note_mismatch("write_data", want.write_data, o_out.write_data);
                if (o_out.last !== want.last)
                    note_mismatch("last", want.last, o_out.last);
            end
        end
        i_out_ready <= ($urandom_range(99) >= gap_pct);
    end

    // ------------------------------------------------------------------------
    // Watchdog: no handshake on either side for too long ends the run
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_in_item attr_op(input logic [1:0] op, input logic [4:0] tx,
                                         input logic [3:0] ty, input logic [1:0] pal,
                                         input logic sel);
        t_in_item it;
        it.operation    = op;
        it.tile_x       = tx;
        it.tile_y       = ty;
        it.palette      = pal;
        it.table_select = sel;
        return it;
    endfunction

    // Wait until all items are in and all writes out, then let the block go idle.
    task automatic settle();
        while (attr_ops_q.size() != 0 || i_in_valid || exp_writes_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_GAP) @(negedge i_clk);
    endtask

    task automatic write_base(input logic [CFG_IDX_W-1:0] idx,
                              input logic [ADDR_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx == CFG_TABLE_A)
            base_a = value;
        else
            base_b = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly buffered set runs with locality so the dirty byte gets hit again,
    // plus flushes, stray enables and the occasional upload.
    task automatic queue_random_ops(input int count);
        int         pick;
        logic [4:0] tx;
        logic [3:0] ty;
        attr_ops_q.push_back(attr_op(OP_ENABLE, 5'($urandom), 4'($urandom),
                                     2'($urandom), 1'($urandom)));
        for (int n = 1; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 72) begin
                if ($urandom_range(99) < 35) begin
                    // same byte, possibly another slot
                    tx = near_x ^ 5'($urandom_range(1));
                    ty = near_y ^ 4'($urandom_range(1));
                end else begin
                    tx = 5'($urandom);
                    ty = 4'($urandom);
                end
                near_x = tx;
                near_y = ty;
                attr_ops_q.push_back(attr_op(OP_SET, tx, ty, 2'($urandom), 1'($urandom)));
            end else if (pick < 84) begin
                attr_ops_q.push_back(attr_op(OP_FLUSH, 5'($urandom), 4'($urandom),
                                             2'($urandom), 1'($urandom)));
            end else if (pick < 95) begin
                attr_ops_q.push_back(attr_op(OP_ENABLE, 5'($urandom), 4'($urandom),
                                             2'($urandom), 1'($urandom)));
            end else begin
                attr_ops_q.push_back(attr_op(OP_UPLOAD, 5'($urandom), 4'($urandom),
                                             2'($urandom), 1'($urandom)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        // predictor reset state matches the block's
        for (int i = 0; i < DEPTH; i++)
            shadow_mem[i] = '0;
        dirty_idx = '0;
        dirty_set = 1'b0;
        buffer_en = 1'b0;
        base_a    = TABLE_A_RST;
        base_b    = TABLE_B_RST;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // -- directed, reset bases --------------------------------------------
        attr_ops_q.push_back(attr_op(OP_SET,    5'd0,  4'd0,  2'd3, 1'b0)); // unbuffered set
        attr_ops_q.push_back(attr_op(OP_SET,    5'd31, 4'd15, 2'd2, 1'b1)); // last byte, top slot
        attr_ops_q.push_back(attr_op(OP_FLUSH,  5'd0,  4'd0,  2'd0, 1'b0)); // nothing dirty
        attr_ops_q.push_back(attr_op(OP_ENABLE, 5'd0,  4'd0,  2'd0, 1'b0));
        attr_ops_q.push_back(attr_op(OP_SET,    5'd1,  4'd0,  2'd1, 1'b0)); // first dirty byte
        attr_ops_q.push_back(attr_op(OP_SET,    5'd0,  4'd1,  2'd2, 1'b0)); // same byte again
        attr_ops_q.push_back(attr_op(OP_SET,    5'd16, 4'd14, 2'd3, 1'b0)); // evicts byte 0
        attr_ops_q.push_back(attr_op(OP_SET,    5'd15, 4'd1,  2'd0, 1'b1)); // evicts table-B byte
        attr_ops_q.push_back(attr_op(OP_FLUSH,  5'd0,  4'd0,  2'd0, 1'b0));
        attr_ops_q.push_back(attr_op(OP_FLUSH,  5'd31, 4'd15, 2'd3, 1'b1)); // repeat flush
        attr_ops_q.push_back(attr_op(OP_SET,    5'd2,  4'd2,  2'd1, 1'b0)); // buffering off
        attr_ops_q.push_back(attr_op(OP_FLUSH,  5'd0,  4'd0,  2'd0, 1'b0)); // flush while off
        attr_ops_q.push_back(attr_op(OP_UPLOAD, 5'd0,  4'd0,  2'd0, 1'b0));
        attr_ops_q.push_back(attr_op(OP_UPLOAD, 5'd31, 4'd15, 2'd3, 1'b1));
        attr_ops_q.push_back(attr_op(OP_ENABLE, 5'd0,  4'd0,  2'd0, 1'b0));
        attr_ops_q.push_back(attr_op(OP_FLUSH,  5'd0,  4'd0,  2'd0, 1'b0)); // cleared by enable
        settle();

        // -- directed, extreme bases: table A wraps past the top ---------------
        write_base(CFG_TABLE_A, 14'h3fff);
        write_base(CFG_TABLE_B, 14'h0000);
        attr_ops_q.push_back(attr_op(OP_ENABLE, 5'd0,  4'd0,  2'd0, 1'b0));
        attr_ops_q.push_back(attr_op(OP_SET,    5'd14, 4'd14, 2'd1, 1'b0));
        attr_ops_q.push_back(attr_op(OP_SET,    5'd17, 4'd3,  2'd2, 1'b1)); // evicts A byte
        attr_ops_q.push_back(attr_op(OP_SET,    5'd3,  4'd2,  2'd3, 1'b0)); // evicts B byte
        attr_ops_q.push_back(attr_op(OP_FLUSH,  5'd0,  4'd0,  2'd0, 1'b0));
        attr_ops_q.push_back(attr_op(OP_UPLOAD, 5'd0,  4'd0,  2'd0, 1'b0));
        attr_ops_q.push_back(attr_op(OP_UPLOAD, 5'd0,  4'd0,  2'd0, 1'b1));
        settle();

        // -- random phases across several base settings ------------------------
        write_base(CFG_TABLE_A, 14'h0000);
        write_base(CFG_TABLE_B, 14'h3fff);
        queue_random_ops(70);
        settle();

        write_base(CFG_TABLE_A, 14'($urandom));
        write_base(CFG_TABLE_B, 14'($urandom));
        gap_pct = 0;  // back-to-back on both sides
        queue_random_ops(70);
        settle();
        gap_pct = 17;

        write_base(CFG_TABLE_A, TABLE_A_RST);
        write_base(CFG_TABLE_B, TABLE_B_RST);
        queue_random_ops(70);
        settle();

        write_base(CFG_TABLE_A, 14'($urandom_range(16383, 16000)));
        write_base(CFG_TABLE_B, 14'($urandom));
        queue_random_ops(70);
        settle();

        write_base(CFG_TABLE_B, 14'($urandom_range(16383, 15400)));
        queue_random_ops(70);

        // drain, then watch for stray writes
        while (attr_ops_q.size() != 0 || i_in_valid || exp_writes_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_GAP) @(negedge i_clk);

        if (mismatch_count == 0 && exp_writes_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
hw/rtl/asdu_pkg.sv
hw/rtl/asdu_dp.sv
hw/rtl/asdu_ctrl.sv
hw/rtl/attribute_shadow_dirty_update.sv
dv/attribute_shadow_dirty_update_tb.sv
